// ===== sv/sfpc_pkg.sv =====
// shared types, codes and helpers for the sensor compensation block
`timescale 1ns / 1ps
`default_nettype none
package sfpc_pkg;

  typedef enum logic [1:0] {
    KIND_TEMP  = 2'd0,
    KIND_PRES  = 2'd1,
    KIND_HUMID = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_TEMP   = 3'd0,
    REG_PRES_A = 3'd1,
    REG_PRES_B = 3'd2,
    REG_PRES_9 = 3'd3,
    REG_HUMID  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [19:0] adc_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] reading;
    logic        div_zero;
  } out_item_t;

  typedef enum logic [5:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2,
    S_T0, S_T1, S_T2, S_T3, S_T4,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_DIV, S_P8, S_P9, S_P10, S_P11,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
    S_FIN
  } state_t;

  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned DIV_LAST = 63;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx12(input logic [11:0] v);
    return {{52{v[11]}}, v};
  endfunction

  function automatic logic [63:0] sx8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== sv/sensor_fixed_point_compensation.sv =====
// top level: integer temperature, pressure and humidity compensation
//
//  channel  | ports                               | payload
//  ---------+-------------------------------------+---------------------------
//  input    | in_valid, in_stall, in_data         | opcode, adc_value
//  result   | out_valid, out_stall, out_data      | kind, reading, div_zero
//  config   | cfg_psel/penable/pwrite/paddr/...   | 64-bit calibration words
//
// one request at a time; every multiply goes through one 32x32 multiplier,
// three passes per 64-bit product (low 64 bits kept)
// per request: temperature and humidity run their products only, pressure runs
// ten products plus a restoring divider, and stops before the divider when the pressure
// divisor is zero; unused opcode 3 goes straight to the result; a stalled output holds the block in its last state
// synchronous active-low reset clears control, coefficients and fine temperature
// in_stall is high from accept until the result moves into the output register;
// a stalled result holds there while the next request is already accepted
`timescale 1ns / 1ps
`default_nettype none
module sensor_fixed_point_compensation
  import sfpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [63:0]       cfg_pwdata,
  output logic [63:0]            cfg_prdata,
  output logic                   cfg_pready
);

  // calibration registers
  logic [47:0] temp_r;
  logic [63:0] pa_r, pb_r, hum_r;
  logic [15:0] p9_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  // control
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  // datapath
  logic [31:0] ft_r, ft_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, w_r, w_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt, mr_r, mr_nxt, rem_r, rem_nxt;
  logic        neg_r, neg_nxt, dz_r, dz_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [19:0] adc_r, adc_nxt;
  logic [31:0] res_r, res_nxt;

  // shared multiplier and helper terms
  logic [31:0] mop_a, mop_b, m32;
  logic [63:0] prod;
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;
  logic [63:0] p_v1;
  logic        out_free;

  assign cfg_idx    = cfg_paddr[ADDR_W-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_TEMP:   cfg_prdata = {16'b0, temp_r};
      REG_PRES_A: cfg_prdata = pa_r;
      REG_PRES_B: cfg_prdata = pb_r;
      REG_PRES_9: cfg_prdata = {48'b0, p9_r};
      REG_HUMID:  cfg_prdata = hum_r;
      default:    cfg_prdata = 64'b0;
    endcase
  end

  // unpacked coefficients widened to the 64-bit datapath: t1, p1, h1, h3 zero extended, the rest sign extended
  assign t1 = {48'b0, temp_r[15:0]};
  assign t2 = sx16(temp_r[31:16]);
  assign t3 = sx16(temp_r[47:32]);
  assign p1 = {48'b0, pa_r[15:0]};
  assign p2 = sx16(pa_r[31:16]);
  assign p3 = sx16(pa_r[47:32]);
  assign p4 = sx16(pa_r[63:48]);
  assign p5 = sx16(pb_r[15:0]);
  assign p6 = sx16(pb_r[31:16]);
  assign p7 = sx16(pb_r[47:32]);
  assign p8 = sx16(pb_r[63:48]);
  assign p9 = sx16(p9_r);
  assign h1 = {56'b0, hum_r[7:0]};
  assign h2 = sx16(hum_r[23:8]);
  assign h3 = {56'b0, hum_r[31:24]};
  assign h4 = sx12(hum_r[43:32]);
  assign h5 = sx12(hum_r[55:44]);
  assign h6 = sx8(hum_r[63:56]);

  // one 32x32 partial product per cycle: low*low, low(a)*high(b), high(a)*low(b)
  assign mop_a = (state_r == S_MUL2) ? ma_r[63:32] : ma_r[31:0];
  assign mop_b = (state_r == S_MUL1) ? mb_r[63:32] : mb_r[31:0];
  assign prod  = 64'(mop_a) * 64'(mop_b);
  assign m32   = mr_r[31:0];

  // pressure divisor, tested before the division starts
  assign p_v1     = 64'($signed(mr_r) >>> 33);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            KIND_TEMP:  state_nxt = S_T0;
            KIND_PRES:  state_nxt = S_P0;
            KIND_HUMID: state_nxt = S_H0;
            default:    state_nxt = S_FIN;
          endcase
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = ret_r;
      S_T4, S_P11, S_H8: state_nxt = S_FIN;
      S_P6:   state_nxt = (p_v1 == 64'b0) ? S_FIN : S_MUL0;
      S_P7:   state_nxt = S_DIV;
      S_DIV:  state_nxt = (cnt_r == 6'(DIV_LAST)) ? S_P8 : S_DIV;
      S_FIN:  state_nxt = out_free ? S_IDLE : S_FIN;
      default: state_nxt = S_MUL0;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    logic [31:0] a32, v32;
    logic [63:0] rt_ext;
    logic [64:0] rt, diff;
    a32 = 32'b0;
    v32 = 32'b0;
    rt_ext = 64'b0;
    rt   = 65'b0;
    diff = 65'b0;
    ret_nxt = ret_r;
    cnt_nxt = cnt_r;
    ft_nxt  = ft_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; w_nxt = w_r;
    ma_nxt = ma_r; mb_nxt = mb_r; mr_nxt = mr_r; rem_nxt = rem_r;
    neg_nxt = neg_r; dz_nxt = dz_r;
    op_nxt = op_r; adc_nxt = adc_r; res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        op_nxt  = in_data.opcode;
        adc_nxt = in_data.adc_value;
        res_nxt = 32'b0;
        dz_nxt  = 1'b0;
      end
      S_MUL0: mr_nxt = prod;
      S_MUL1, S_MUL2: mr_nxt = mr_r + {prod[31:0], 32'b0};

      // temperature, 32-bit wrapping
      S_T0: begin
        a32 = 32'(adc_r >> 3) - (t1[31:0] << 1);
        ma_nxt = sx32(a32); mb_nxt = t2; ret_nxt = S_T1;
      end
      S_T1: begin
        y_nxt = sx32(32'($signed(m32) >>> 11));
        a32 = 32'(adc_r >> 4) - t1[31:0];
        ma_nxt = sx32(a32); mb_nxt = sx32(a32); ret_nxt = S_T2;
      end
      S_T2: begin
        ma_nxt = sx32(32'($signed(m32) >>> 12)); mb_nxt = t3; ret_nxt = S_T3;
      end
      S_T3: begin
        a32 = y_r[31:0] + 32'($signed(m32) >>> 14);
        ft_nxt = a32;
        ma_nxt = sx32(a32); mb_nxt = 64'd5; ret_nxt = S_T4;
      end
      S_T4: res_nxt = 32'($signed(m32 + 32'd128) >>> 8);

      // pressure, 64-bit wrapping
      S_P0: begin
        x_nxt = sx32(ft_r) - 64'd128000;
        ma_nxt = x_nxt; mb_nxt = x_nxt; ret_nxt = S_P1;
      end
      S_P1: begin
        y_nxt = mr_r; ma_nxt = mr_r; mb_nxt = p6; ret_nxt = S_P2;
      end
      S_P2: begin
        z_nxt = mr_r; ma_nxt = x_r; mb_nxt = p5; ret_nxt = S_P3;
      end
      S_P3: begin
        z_nxt = z_r + (mr_r << 17) + (p4 << 35);
        ma_nxt = y_r; mb_nxt = p3; ret_nxt = S_P4;
      end
      S_P4: begin
        w_nxt = 64'($signed(mr_r) >>> 8);
        ma_nxt = x_r; mb_nxt = p2; ret_nxt = S_P5;
      end
      S_P5: begin
        w_nxt = w_r + (mr_r << 12);
        ma_nxt = (64'd1 << 47) + w_nxt; mb_nxt = p1; ret_nxt = S_P6;
      end
      S_P6: begin
        x_nxt = p_v1;
        if (p_v1 == 64'b0) begin
          dz_nxt  = 1'b1;
          res_nxt = 32'b0;
        end else begin
          y_nxt = ((64'd1048576 - 64'(adc_r)) << 31) - z_r;
          ma_nxt = y_nxt; mb_nxt = 64'd3125; ret_nxt = S_P7;
        end
      end
      S_P7: begin
        // magnitudes into the restoring divider
        neg_nxt = mr_r[63] ^ x_r[63];
        w_nxt   = mr_r[63] ? (64'b0 - mr_r) : mr_r;
        x_nxt   = x_r[63] ? (64'b0 - x_r) : x_r;
        rem_nxt = 64'b0;
        cnt_nxt = 6'b0;
      end
      S_DIV: begin
        rt   = {rem_r, w_r[63]};
        diff = rt - {1'b0, x_r};
        if (!diff[64]) begin
          rem_nxt = diff[63:0];
        end else begin
          rem_nxt = rt[63:0];
        end
        w_nxt   = {w_r[62:0], !diff[64]};
        cnt_nxt = cnt_r + 6'd1;
      end
      S_P8: begin
        rt_ext = neg_r ? (64'b0 - w_r) : w_r;
        x_nxt  = rt_ext;
        ma_nxt = p9; mb_nxt = 64'($signed(rt_ext) >>> 13); ret_nxt = S_P9;
      end
      S_P9: begin
        ma_nxt = mr_r; mb_nxt = 64'($signed(x_r) >>> 13); ret_nxt = S_P10;
      end
      S_P10: begin
        y_nxt = 64'($signed(mr_r) >>> 25);
        ma_nxt = p8; mb_nxt = x_r; ret_nxt = S_P11;
      end
      S_P11: begin
        z_nxt  = 64'($signed(mr_r) >>> 19);
        rt_ext = 64'($signed(x_r + y_r + z_nxt) >>> 8) + (p7 << 4);
        res_nxt = rt_ext[31:0];
      end

      // humidity, 32-bit wrapping
      S_H0: begin
        x_nxt = sx32(ft_r - 32'd76800);
        ma_nxt = h5; mb_nxt = x_nxt; ret_nxt = S_H1;
      end
      S_H1: begin
        a32 = (32'(adc_r[15:0]) << 14) - (h4[31:0] << 20) - m32;
        y_nxt = sx32(32'($signed(a32 + 32'd16384) >>> 15));
        ma_nxt = x_r; mb_nxt = h6; ret_nxt = S_H2;
      end
      S_H2: begin
        z_nxt = sx32(32'($signed(m32) >>> 10));
        ma_nxt = x_r; mb_nxt = h3; ret_nxt = S_H3;
      end
      S_H3: begin
        ma_nxt = z_r;
        mb_nxt = sx32(32'($signed(m32) >>> 11) + 32'd32768);
        ret_nxt = S_H4;
      end
      S_H4: begin
        w_nxt = sx32(32'($signed(m32) >>> 10) + 32'd2097152);
        ma_nxt = w_nxt; mb_nxt = h2; ret_nxt = S_H5;
      end
      S_H5: begin
        w_nxt = sx32(32'($signed(m32 + 32'd8192) >>> 14));
        ma_nxt = y_r; mb_nxt = w_nxt; ret_nxt = S_H6;
      end
      S_H6: begin
        z_nxt = sx32(m32);
        a32 = 32'($signed(m32) >>> 15);
        ma_nxt = sx32(a32); mb_nxt = sx32(a32); ret_nxt = S_H7;
      end
      S_H7: begin
        ma_nxt = sx32(32'($signed(m32) >>> 7)); mb_nxt = h1; ret_nxt = S_H8;
      end
      S_H8: begin
        v32 = z_r[31:0] - 32'($signed(m32) >>> 4);
        if (v32[31]) begin
          v32 = 32'b0;
        end else if (v32 > 32'd419430400) begin
          v32 = 32'd419430400;
        end
        res_nxt = v32 >> 12;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.kind     = op_r;
          out_data_nxt.reading  = res_r;
          out_data_nxt.div_zero = dz_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= 6'b0;
      out_valid_r <= 1'b0;
      ft_r        <= 32'b0;
      temp_r      <= 48'b0;
      pa_r        <= 64'b0;
      pb_r        <= 64'b0;
      p9_r        <= 16'b0;
      hum_r       <= 64'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ft_r        <= ft_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_TEMP:   temp_r <= cfg_pwdata[47:0];
          REG_PRES_A: pa_r   <= cfg_pwdata;
          REG_PRES_B: pb_r   <= cfg_pwdata;
          REG_PRES_9: p9_r   <= cfg_pwdata[15:0];
          REG_HUMID:  hum_r  <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; w_r <= w_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; mr_r <= mr_nxt; rem_r <= rem_nxt;
    neg_r <= neg_nxt; dz_r <= dz_nxt;
    op_r <= op_nxt; adc_r <= adc_nxt; res_r <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== dv/tb_sensor_fixed_point_compensation.sv =====
// testbench for the sensor compensation block: table and random requests against a predictor
`timescale 1ns / 1ps
module tb_sensor_fixed_point_compensation;
  import sfpc_pkg::*;

  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 250;
  localparam int STALL_LEN = 2000;  // long receiver hold-off, in cycles
  localparam int WD_LIMIT  = 20000; // cycles with no transfer before giving up
  localparam int N_ZERO    = 4;     // table rows run on reset calibration

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  sensor_fixed_point_compensation u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // calibration shadow and the kept fine temperature
  logic [63:0] cal_temp, cal_pres_a, cal_pres_b, cal_pres_9, cal_humid;
  int fine_t;

  out_item_t readings_due[$];
  int n_errors = 0;
  int n_got = 0;
  bit quiet = 1'b0;   // no idling on either side while set

  // directed table: a typed expectation only where calibration is all zero
  typedef struct {
    kind_t       op;
    logic [19:0] adc;
    bit          typed;
    logic [31:0] reading;
    logic        dz;
  } row_t;

  row_t rows[] = '{
    '{KIND_TEMP,  20'h7EED0, 1'b1, 32'd0, 1'b0},
    '{KIND_PRES,  20'h655AC, 1'b1, 32'd0, 1'b1},  // zero calibration: divisor zero
    '{KIND_HUMID, 20'hFFFFF, 1'b1, 32'd0, 1'b0},
    '{KIND_NONE,  20'hFFFFF, 1'b1, 32'd0, 1'b0},
    '{KIND_PRES,  20'h655AC, 1'b0, 32'd0, 1'b0},  // pressure before any temperature on the loaded calibration
    '{KIND_TEMP,  20'h7EED0, 1'b0, 32'd0, 1'b0},
    '{KIND_PRES,  20'h655AC, 1'b0, 32'd0, 1'b0},
    '{KIND_PRES,  20'h00000, 1'b0, 32'd0, 1'b0},
    '{KIND_PRES,  20'hFFFFF, 1'b0, 32'd0, 1'b0},
    '{KIND_HUMID, 20'h0A0B0, 1'b0, 32'd0, 1'b0},
    '{KIND_HUMID, 20'h00000, 1'b0, 32'd0, 1'b0},  // clamps at zero
    '{KIND_HUMID, 20'h0FFFF, 1'b0, 32'd0, 1'b0},  // clamps at full scale
    '{KIND_HUMID, 20'hF0000, 1'b0, 32'd0, 1'b0},  // upper sample bits ignored
    '{KIND_TEMP,  20'h00000, 1'b0, 32'd0, 1'b0},
    '{KIND_HUMID, 20'h08000, 1'b0, 32'd0, 1'b0},
    '{KIND_TEMP,  20'hFFFFF, 1'b0, 32'd0, 1'b0},
    '{KIND_PRES,  20'h80000, 1'b0, 32'd0, 1'b0},
    '{KIND_NONE,  20'h00000, 1'b0, 32'd0, 1'b0},
    '{KIND_HUMID, 20'h0FFFF, 1'b0, 32'd0, 1'b0}
  };

  // signed division truncating toward zero, wrapping on overflow
  function automatic longint div_trunc(longint n, longint d);
    logic [63:0] un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // compensated reading for one request; a temperature request updates fine_t
  function automatic out_item_t compensate(in_item_t req);
    out_item_t res;
    int adc_i, t1, t2, t3, a, b, h1, h2, h3, h4, h5, h6, x, y, s, v;
    longint q1, q2, q3, q4, q5, q6, q7, q8, q9, w1, w2, p;
    adc_i = {12'd0, req.adc_value};
    res = '0;
    res.kind = req.opcode;
    case (kind_t'(req.opcode))
      KIND_TEMP: begin
        t1 = {16'd0, cal_temp[15:0]};
        t2 = int'($signed(cal_temp[31:16]));
        t3 = int'($signed(cal_temp[47:32]));
        a = (adc_i >>> 3) - (t1 << 1);
        b = (adc_i >>> 4) - t1;
        fine_t = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
        res.reading = (fine_t * 5 + 128) >>> 8;
      end
      KIND_PRES: begin
        q1 = longint'({48'd0, cal_pres_a[15:0]});
        q2 = longint'($signed(cal_pres_a[31:16]));
        q3 = longint'($signed(cal_pres_a[47:32]));
        q4 = longint'($signed(cal_pres_a[63:48]));
        q5 = longint'($signed(cal_pres_b[15:0]));
        q6 = longint'($signed(cal_pres_b[31:16]));
        q7 = longint'($signed(cal_pres_b[47:32]));
        q8 = longint'($signed(cal_pres_b[63:48]));
        q9 = longint'($signed(cal_pres_9[15:0]));
        w1 = longint'(fine_t) - 128000;
        w2 = w1 * w1 * q6 + ((w1 * q5) << 17) + (q4 << 35);
        w1 = ((w1 * w1 * q3) >>> 8) + ((w1 * q2) << 12);
        w1 = (((64'sd1 <<< 47) + w1) * q1) >>> 33;
        if (w1 == 0) begin
          res.div_zero = 1'b1;
        end else begin
          p = 1048576 - longint'(adc_i);
          p = div_trunc(((p << 31) - w2) * 3125, w1);
          w1 = (q9 * (p >>> 13) * (p >>> 13)) >>> 25;
          w2 = (q8 * p) >>> 19;
          p = ((p + w1 + w2) >>> 8) + (q7 << 4);
          res.reading = p[31:0];
        end
      end
      KIND_HUMID: begin
        h1 = {24'd0, cal_humid[7:0]};
        h2 = int'($signed(cal_humid[23:8]));
        h3 = {24'd0, cal_humid[31:24]};
        h4 = int'($signed(cal_humid[43:32]));
        h5 = int'($signed(cal_humid[55:44]));
        h6 = int'($signed(cal_humid[63:56]));
        v = fine_t - 76800;
        x = ((adc_i & 32'hFFFF) << 14) - (h4 << 20) - h5 * v;
        x = (x + 16384) >>> 15;
        y = ((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768);
        y = (y >>> 10) + 2097152;
        y = (y * h2 + 8192) >>> 14;
        v = x * y;
        s = v >>> 15;
        v = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0) v = 0;
        else if (v > 419430400) v = 419430400;
        res.reading = v >>> 12;
      end
      default: ;
    endcase
    return res;
  endfunction

  // register write with a setup and an access phase; the shadow follows the written register
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'(idx) << 3;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_TEMP:   cal_temp = val & 64'hFFFF_FFFF_FFFF;
      REG_PRES_A: cal_pres_a = val;
      REG_PRES_B: cal_pres_b = val;
      REG_PRES_9: cal_pres_9 = val & 64'hFFFF;
      REG_HUMID:  cal_humid = val;
      default: ;
    endcase
  endtask

  task automatic load_cal(logic [63:0] tv, logic [63:0] pa, logic [63:0] pb,
                          logic [63:0] p9, logic [63:0] hv);
    write_reg(REG_TEMP, tv);
    write_reg(REG_PRES_A, pa);
    write_reg(REG_PRES_B, pb);
    write_reg(REG_PRES_9, p9);
    write_reg(REG_HUMID, hv);
  endtask

  // sender pauses until every reading is back, then lets the block settle
  task automatic drain();
    while (readings_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // offer one request with random leading gaps; predict on acceptance
  task automatic send(in_item_t req, bit typed, out_item_t typed_res);
    out_item_t res;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    res = compensate(req);
    readings_due.push_back(typed ? typed_res : res);
  endtask

  task automatic send_random();
    in_item_t req;
    int r;
    r = $urandom_range(99);
    // temperature refreshes mixed with pressure, humidity and the occasional unused opcode
    req.opcode = (r < 30) ? KIND_TEMP : (r < 62) ? KIND_PRES : (r < 94) ? KIND_HUMID : KIND_NONE;
    req.adc_value = 20'($urandom());
    send(req, 1'b0, '0);
  endtask

  // receiver: random stall, and one long hold-off that fills the block
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_got == 500) begin
        held = 1'b1;
        hold = STALL_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 33);
      end
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_got++;
      if (readings_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, actual %p", $time, out_data);
      end else begin
        want = readings_due.pop_front();
        if (out_data.kind !== want.kind) begin
          n_errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
        end
        if (out_data.reading !== want.reading) begin
          n_errors++;
          $display("%0t: reading expected %0d actual %0d", $time,
                   $signed(want.reading), $signed(out_data.reading));
        end
        if (out_data.div_zero !== want.div_zero) begin
          n_errors++;
          $display("%0t: div_zero expected %0b actual %0b", $time,
                   want.div_zero, out_data.div_zero);
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    in_item_t req;
    out_item_t typed_res;
    logic [63:0] tv, pa, pb, p9, hv;
    cal_temp = '0;
    cal_pres_a = '0;
    cal_pres_b = '0;
    cal_pres_9 = '0;
    cal_humid = '0;
    fine_t = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, first rows on reset calibration
    foreach (rows[i]) begin
      if (i == N_ZERO) begin
        @(negedge clk);
        in_valid <= 1'b0;
        drain();
        // typical calibration words of a real part
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 64'd6000,
                 {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
      end
      req.opcode = rows[i].op;
      req.adc_value = rows[i].adc;
      typed_res.kind = rows[i].op;
      typed_res.reading = rows[i].reading;
      typed_res.div_zero = rows[i].dz;
      send(req, rows[i].typed, typed_res);
    end

    // random phases across calibration settings, extremes among them
    for (int ph = 0; ph < N_PHASES; ph++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      drain();
      case (ph)
        0: begin tv = cal_temp; pa = cal_pres_a; pb = cal_pres_b;
                 p9 = cal_pres_9; hv = cal_humid; end
        1: begin tv = '1; pa = '1; pb = '1; p9 = '1; hv = '1; end
        2: begin tv = 64'h8000_8000_8000_8000; pa = 64'h8000_8000_8000_FFFF;
                 pb = 64'h8000_8000_8000_8000; p9 = 64'h8000;
                 hv = 64'h8080_0800_FF80_00FF; end
        3: begin tv = 64'h7FFF_7FFF_FFFF; pa = 64'h7FFF_7FFF_7FFF_FFFF;
                 pb = 64'h7FFF_7FFF_7FFF_7FFF; p9 = 64'h7FFF;
                 hv = 64'h7F7F_F7FF_FF7F_FFFF; end
        default: begin
          tv = {$urandom(), $urandom()}; pa = {$urandom(), $urandom()};
          pb = {$urandom(), $urandom()}; p9 = {$urandom(), $urandom()};
          hv = {$urandom(), $urandom()};
        end
      endcase
      load_cal(tv, pa, pb, p9, hv);
      quiet = (ph == 4);
      for (int k = 0; k < PHASE_LEN; k++) send_random();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;
    drain();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
